>>> sv/bounded_array_table_engine_top_defines.svh
// assertion macros for the bounded array table engine checkers
`ifndef BOUNDED_ARRAY_TABLE_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_ARRAY_TABLE_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define BATE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bate check failed");

// next-cycle implication
`define BATE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bate check failed");

`endif

>>> sv/bate_pkg.sv
// shared types and codes for the bounded array table engine
package bate_pkg;

  typedef enum logic [3:0] {
    OP_APPEND  = 4'd0,
    OP_INSERT  = 4'd1,
    OP_DELETE  = 4'd2,
    OP_SET     = 4'd3,
    OP_SEARCH  = 4'd4,
    OP_MIN     = 4'd5,
    OP_MAX     = 4'd6,
    OP_SUM     = 4'd7,
    OP_REVERSE = 4'd8,
    OP_LSHIFT  = 4'd9,
    OP_LROT    = 4'd10,
    OP_RSHIFT  = 4'd11,
    OP_RROT    = 4'd12
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] sum;
    logic               lt;
    logic               eq;
  } alu_res_t;

  typedef enum logic [16:0] {
    S_IDLE  = 17'b00000000000000001,
    S_START = 17'b00000000000000010,
    S_DCAP  = 17'b00000000000000100,
    S_MOD   = 17'b00000000000001000,
    S_MRD   = 17'b00000000000010000,
    S_MWR   = 17'b00000000000100000,
    S_FILL  = 17'b00000000001000000,
    S_SRD   = 17'b00000000010000000,
    S_SACC  = 17'b00000000100000000,
    S_BRD   = 17'b00000001000000000,
    S_BCMP  = 17'b00000010000000000,
    S_SEG   = 17'b00000100000000000,
    S_RA    = 17'b00001000000000000,
    S_RB    = 17'b00010000000000000,
    S_WA    = 17'b00100000000000000,
    S_WB    = 17'b01000000000000000,
    S_OUT   = 17'b10000000000000000
  } state_t;

endpackage

>>> sv/bate_in_if.sv
// operation channel: valid, ready and one operation
interface bate_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         op;
  logic [6:0]         position;
  logic signed [31:0] value;
  logic [7:0]         amount;

  modport source (output valid, op, position, value, amount, input ready);
  modport sink (input valid, op, position, value, amount, output ready);
endinterface

>>> sv/bate_out_if.sv
// result channel: valid, ready and one result
interface bate_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] result_value;
  logic [6:0]         list_length;

  modport source (output valid, status, result_value, list_length, input ready);
  modport sink (input valid, status, result_value, list_length, output ready);
endinterface

>>> sv/bate_alu.sv
// shared add, subtract and signed compare unit
module bate_alu (
  input  bate_pkg::alu_req_t req,
  output bate_pkg::alu_res_t res
);
  import bate_pkg::*;

  always_comb begin
    res.sum = req.sub ? (req.a - req.b) : (req.a + req.b);
    res.lt  = req.a < req.b;
    res.eq  = req.a == req.b;
  end
endmodule

>>> sv/bate_mem.sv
// element store: one write port, one registered read port
module bate_mem #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [31:0]   wdata,
  input  logic [AW-1:0]        raddr,
  output logic signed [31:0]   rdata
);
  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/bounded_array_table_engine_top.sv
// bounded array table engine: list of signed words under a one-port sequencer
// Operations arrive on in_ch (valid/ready); each transfer gives exactly one
// result on out_ch with status, result value and the list length afterwards.
// cfg_we/cfg_wdata write the capacity limit; write it only while idle.
// One operation at a time: in_ch.ready is high only while the sequencer idles.
// Each operation walks the sequencer states, with registered store reads:
//   append, set, rejects, empty cases: straight to the result state, the
//   result being registered; insert, delete, shifts: a read and a write
//   state per moved entry, then a fill state per cleared entry
//   min, max, sum: a read and an accumulate state per entry; search: a read
//   and a compare state per halving step; reverse: two reads and two writes
//   per swapped pair; rotations: repeated subtraction, then three reversals
// Reset (synchronous, active high) empties the list and sets the capacity
// limit to 64; the store itself is not cleared, entries past the length are
// never read.
// A stalled result holds on out_ch until taken; no new operation is accepted
// meanwhile.
module bounded_array_table_engine_top #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  bate_in_if.sink    in_ch,
  bate_out_if.source out_ch
);
  import bate_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_t             state;
  logic [6:0]         count;
  logic [6:0]         cap;
  logic [6:0]         n_r;
  logic [3:0]         op_r;
  logic signed [31:0] val_r;
  logic [7:0]         i;
  logic [7:0]         off;
  logic               dir_up;
  logic [7:0]         cnt;
  logic [7:0]         fill_i;
  logic [7:0]         fill_cnt;
  logic signed [31:0] fillv;
  logic [7:0]         k;
  logic [7:0]         a;
  logic [7:0]         b;
  logic [1:0]         phase;
  logic signed [31:0] tmp;
  logic signed [8:0]  lo;
  logic signed [8:0]  hi;
  logic [1:0]         status_r;
  logic signed [31:0] res_r;

  logic [6:0]         lim;
  logic [7:0]         nn;
  logic [7:0]         nr8;
  logic [7:0]         ks;
  logic [7:0]         src;
  logic signed [9:0]  lh;
  logic signed [8:0]  mid;
  logic [7:0]         seg_a;
  logic [7:0]         seg_b;
  logic               accept;

  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rdata;
  alu_req_t           alu_req;
  alu_res_t           alu_res;

  bate_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bate_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign accept = in_ch.valid && in_ch.ready;
  assign lim = (CAPACITY > 127 || cap < 7'(CAPACITY)) ? cap : 7'(CAPACITY);
  assign nn  = {1'b0, count};
  assign nr8 = {1'b0, n_r};
  assign ks  = (in_ch.amount < nn) ? in_ch.amount : nn;
  assign src = dir_up ? (i + off) : (i - off);
  assign lh  = 10'(lo) + 10'(hi);
  assign mid = lh[9:1];

  // reversal segments for reverse and rotations
  always_comb begin
    seg_a = '0;
    seg_b = nr8 - 8'd1;
    if (op_r == OP_LROT) begin
      unique case (phase)
        2'd0: begin seg_a = '0; seg_b = k - 8'd1; end
        2'd1: begin seg_a = k;  seg_b = nr8 - 8'd1; end
        default: begin seg_a = '0; seg_b = nr8 - 8'd1; end
      endcase
    end else if (op_r == OP_RROT) begin
      unique case (phase)
        2'd0: begin seg_a = '0; seg_b = nr8 - 8'd1; end
        2'd1: begin seg_a = '0; seg_b = k - 8'd1; end
        default: begin seg_a = k; seg_b = nr8 - 8'd1; end
      endcase
    end
  end

  // store port and shared unit steering
  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = rdata;
    raddr   = '0;
    alu_req = '{a: rdata, b: res_r, sub: 1'b0};
    unique case (state)
      S_IDLE: begin
        raddr = AW'(in_ch.position);
        if (accept && in_ch.op == OP_APPEND && count < lim) begin
          we    = 1'b1;
          waddr = AW'(count);
          wdata = in_ch.value;
        end else if (accept && in_ch.op == OP_SET && in_ch.position < count) begin
          we    = 1'b1;
          waddr = AW'(in_ch.position);
          wdata = in_ch.value;
        end
      end
      S_MRD: raddr = AW'(src);
      S_MWR: begin
        we    = 1'b1;
        waddr = AW'(i);
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = AW'(fill_i);
        wdata = fillv;
      end
      S_SRD: raddr = AW'(i);
      S_SACC: begin
        if (op_r == OP_MAX) begin
          alu_req = '{a: res_r, b: rdata, sub: 1'b0};
        end
      end
      S_BRD: raddr = AW'($unsigned(mid));
      S_BCMP: alu_req = '{a: rdata, b: val_r, sub: 1'b0};
      S_MOD: alu_req = '{a: 32'(k), b: 32'(n_r), sub: 1'b1};
      S_RA: raddr = AW'(a);
      S_RB: raddr = AW'(b);
      S_WA: begin
        we    = 1'b1;
        waddr = AW'(a);
      end
      S_WB: begin
        we    = 1'b1;
        waddr = AW'(b);
        wdata = tmp;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cap   <= CAP_RESET;
      phase <= '0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status_r <= ST_OK;
            res_r    <= '0;
            n_r      <= count;
            op_r     <= in_ch.op;
            val_r    <= in_ch.value;
            fill_cnt <= '0;
            state    <= S_OUT;
            case (in_ch.op)
              OP_APPEND: begin
                if (count < lim) count <= count + 7'd1;
                else status_r <= ST_REJECT;
              end
              OP_INSERT: begin
                if (in_ch.position <= count && count < lim) begin
                  count    <= count + 7'd1;
                  i        <= nn;
                  off      <= 8'd1;
                  dir_up   <= 1'b0;
                  cnt      <= nn - {1'b0, in_ch.position};
                  fill_i   <= {1'b0, in_ch.position};
                  fill_cnt <= 8'd1;
                  fillv    <= in_ch.value;
                  state    <= S_START;
                end else begin
                  status_r <= ST_REJECT;
                end
              end
              OP_DELETE: begin
                if (in_ch.position < count) begin
                  count  <= count - 7'd1;
                  i      <= {1'b0, in_ch.position};
                  off    <= 8'd1;
                  dir_up <= 1'b1;
                  cnt    <= nn - {1'b0, in_ch.position} - 8'd1;
                  state  <= S_DCAP;
                end else begin
                  status_r <= ST_REJECT;
                end
              end
              OP_SET: begin
                if (in_ch.position >= count) status_r <= ST_REJECT;
              end
              OP_SEARCH: begin
                status_r <= ST_NOTFOUND;
                res_r    <= -32'sd1;
                lo       <= '0;
                hi       <= $signed({2'b00, count}) - 9'sd1;
                if (count != '0) state <= S_BRD;
              end
              OP_MIN, OP_MAX: begin
                i <= '0;
                if (count == '0) status_r <= ST_EMPTY;
                else state <= S_SRD;
              end
              OP_SUM: begin
                i <= '0;
                if (count != '0) state <= S_SRD;
              end
              OP_REVERSE: begin
                phase <= 2'd2;
                if (count > 7'd1) state <= S_SEG;
              end
              OP_LSHIFT: begin
                i        <= '0;
                off      <= ks;
                dir_up   <= 1'b1;
                cnt      <= nn - ks;
                fill_i   <= nn - ks;
                fill_cnt <= ks;
                fillv    <= '0;
                if (count != '0) state <= S_START;
              end
              OP_RSHIFT: begin
                i        <= nn - 8'd1;
                off      <= ks;
                dir_up   <= 1'b0;
                cnt      <= nn - ks;
                fill_i   <= '0;
                fill_cnt <= ks;
                fillv    <= '0;
                if (count != '0) state <= S_START;
              end
              OP_LROT, OP_RROT: begin
                k <= in_ch.amount;
                if (count != '0) state <= S_MOD;
              end
              default: status_r <= ST_REJECT;
            endcase
          end
        end
        S_DCAP: begin
          res_r <= rdata;
          state <= S_START;
        end
        S_START: begin
          if (cnt != '0) state <= S_MRD;
          else if (fill_cnt != '0) state <= S_FILL;
          else state <= S_OUT;
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          i   <= dir_up ? (i + 8'd1) : (i - 8'd1);
          cnt <= cnt - 8'd1;
          if (cnt != 8'd1) state <= S_MRD;
          else if (fill_cnt != '0) state <= S_FILL;
          else state <= S_OUT;
        end
        S_FILL: begin
          fill_i   <= fill_i + 8'd1;
          fill_cnt <= fill_cnt - 8'd1;
          if (fill_cnt == 8'd1) state <= S_OUT;
        end
        S_SRD: state <= S_SACC;
        S_SACC: begin
          if (op_r == OP_SUM) res_r <= alu_res.sum;
          else if (i == '0 || alu_res.lt) res_r <= rdata;
          i <= i + 8'd1;
          if (i == nr8 - 8'd1) state <= S_OUT;
          else state <= S_SRD;
        end
        S_BRD: state <= S_BCMP;
        S_BCMP: begin
          if (alu_res.eq) begin
            status_r <= ST_OK;
            res_r    <= 32'(mid) + 32'sd1;
            state    <= S_OUT;
          end else if (alu_res.lt) begin
            lo <= mid + 9'sd1;
            if (mid + 9'sd1 > hi) state <= S_OUT;
            else state <= S_BRD;
          end else begin
            hi <= mid - 9'sd1;
            if (lo > mid - 9'sd1) state <= S_OUT;
            else state <= S_BRD;
          end
        end
        S_MOD: begin
          if (alu_res.lt) begin
            phase <= 2'd0;
            if (k == '0) state <= S_OUT;
            else state <= S_SEG;
          end else begin
            k <= alu_res.sum[7:0];
          end
        end
        S_SEG: begin
          if (seg_a < seg_b) begin
            a     <= seg_a;
            b     <= seg_b;
            state <= S_RA;
          end else if (phase == 2'd2) begin
            state <= S_OUT;
          end else begin
            phase <= phase + 2'd1;
          end
        end
        S_RA: state <= S_RB;
        S_RB: begin
          tmp   <= rdata;
          state <= S_WA;
        end
        S_WA: state <= S_WB;
        S_WB: begin
          a <= a + 8'd1;
          b <= b - 8'd1;
          if (a + 8'd1 < b - 8'd1) begin
            state <= S_RA;
          end else if (phase == 2'd2) begin
            state <= S_OUT;
          end else begin
            phase <= phase + 2'd1;
            state <= S_SEG;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = (state == S_OUT);
  assign out_ch.status       = status_r;
  assign out_ch.result_value = res_r;
  assign out_ch.list_length  = count;
endmodule

>>> sv/bate_checker.sv
// port-level checks for the bounded array table engine, bound to the top level
`include "bounded_array_table_engine_top_defines.svh"

module bate_checker (
  input logic        clk,
  input logic        rst,
  bate_in_if.sink    in_ch,
  bate_out_if.source out_ch
);
  import bate_pkg::*;

  `BATE_ASSERT_NOW(a_busy_excl, in_ch.ready, !out_ch.valid)
  `BATE_ASSERT_NEXT(a_busy_after_in, in_ch.valid && in_ch.ready, !in_ch.ready)
  `BATE_ASSERT_NEXT(a_idle_after_out, out_ch.valid && out_ch.ready, in_ch.ready)
  `BATE_ASSERT_NOW(a_empty_zero, out_ch.valid && out_ch.status == ST_EMPTY,
    out_ch.result_value == 32'sd0 && out_ch.list_length == 7'd0)
endmodule

bind bounded_array_table_engine_top bate_checker u_bate_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
